>>> rtl/macd_pkg.sv
`timescale 1ns / 1ps
package macd_pkg;
  localparam int PriceW = 32;
  localparam int ValW   = 64;
  localparam logic [1:0] RegFast   = 2'd0;
  localparam logic [1:0] RegSlow   = 2'd1;
  localparam logic [1:0] RegSignal = 2'd2;
  localparam logic [1:0] RegSpare  = 2'd3;

  typedef struct packed {
    logic signed [PriceW-1:0] price;
    logic                     restart;
  } in_t;

  typedef struct packed {
    logic signed [PriceW-1:0] macd_value;
    logic signed [PriceW-1:0] signal_value;
    logic signed [PriceW-1:0] histogram_value;
    logic                     macd_valid;
    logic                     signal_valid;
  } out_t;

  typedef struct packed {
    logic [1:0] index;
    logic [7:0] data;
  } cfg_t;
endpackage

>>> rtl/macd_if.sv
`timescale 1ns / 1ps
interface macd_in_if;
  logic valid;
  logic ready;
  macd_pkg::in_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface macd_out_if;
  logic valid;
  logic ready;
  macd_pkg::out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface macd_cfg_if;
  logic valid;
  logic ready;
  macd_pkg::cfg_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> rtl/macd_div.sv
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle, floor quotient of signed
// dividend by positive divisor.
module macd_div #(
  parameter int NumW = 64,
  parameter int DenW = 18
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic signed [NumW-1:0] num_i,
  input  logic        [DenW-1:0] den_i,
  output logic                   done_o,
  output logic signed [NumW-1:0] quo_o
);
  localparam int CntW = $clog2(NumW + 1);
  logic [NumW-1:0] mag_q, mag_d;
  logic [NumW-1:0] quo_q, quo_d;
  logic [DenW:0]   rem_q, rem_d;
  logic [DenW-1:0] den_q, den_d;
  logic            neg_q, neg_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [DenW:0]   trial;
  logic [NumW-1:0] neg_num;
  logic [NumW-1:0] qfin;

  assign neg_num = ~num_i + 1'b1;
  assign trial = {rem_q[DenW-1:0], mag_q[NumW-1]};
  // floor for negatives: -(q + (r != 0))
  assign qfin = neg_q ? (~(quo_q + {{(NumW-1){1'b0}}, (rem_q != '0)}) + 1'b1) : quo_q;

  always_comb begin
    mag_d = mag_q; quo_d = quo_q; rem_d = rem_q; den_d = den_q; neg_d = neg_q;
    cnt_d = cnt_q; busy_d = busy_q; done_d = 1'b0;
    if (start_i) begin
      neg_d = num_i[NumW-1];
      mag_d = num_i[NumW-1] ? neg_num : num_i;
      den_d = den_i; rem_d = '0; quo_d = '0;
      cnt_d = CntW'(NumW); busy_d = 1'b1;
    end else if (busy_q) begin
      mag_d = {mag_q[NumW-2:0], 1'b0};
      if (trial >= {1'b0, den_q}) begin
        rem_d = trial - {1'b0, den_q};
        quo_d = {quo_q[NumW-2:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[NumW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; cnt_q <= cnt_d;
    end
  end
  always_ff @(posedge clk_i) begin
    mag_q <= mag_d; quo_q <= quo_d; rem_q <= rem_d; den_q <= den_d; neg_q <= neg_d;
  end

  assign done_o = done_q;
  assign quo_o  = qfin;
endmodule

>>> rtl/macd_indicator.sv
`timescale 1ns / 1ps
// MACD indicator: fast/slow EMA of a Q16.16 price, macd = fast - slow,
// signal EMA of macd and histogram = macd - signal. EMAs are seeded by the
// mean of their first period samples.
// Channels: in_ch (price, restart), out_ch (one result beat per input beat),
// cfg_ch (index 0 fast, 1 slow, 2 signal period; a write to index 0-2 clears state).
// Each EMA update or seed mean is one pass of the shared bit-serial divider;
// with all three averages running a beat takes three divider passes.
// in_ch.ready and cfg_ch.ready are high only while the block is idle and
// the output register is empty; an input beat waits while a config beat is
// offered, so one beat is in flight at a time.
// Reset: periods return to 12/26/9 and all averages clear.
// Output stall: the result holds in the output register until taken; no
// new input beat is accepted meanwhile.
module macd_indicator #(
  parameter int PERIOD_BITS = 8,
  parameter int PRICE_FRAC_BITS = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  macd_in_if.sink    in_ch,
  macd_out_if.source out_ch,
  macd_cfg_if.sink   cfg_ch
);
  import macd_pkg::*;
  localparam int VW = ValW;
  localparam int DW = PERIOD_BITS + 2;
  localparam logic [PERIOD_BITS-1:0] PMax = {PERIOD_BITS{1'b1}};
  localparam logic signed [VW-1:0] GOne = VW'(64'sd1 <<< PRICE_FRAC_BITS);

  localparam logic [3:0] SIdle = 4'd0, SFast = 4'd1, SFastW = 4'd2, SSlow = 4'd3,
    SSlowW = 4'd4, SMacd = 4'd5, SSig = 4'd6, SSigW = 4'd7, SOut = 4'd8,
    SGSeed = 4'd11;

  logic [3:0] st_q, st_d;
  logic [PERIOD_BITS-1:0] fp_q, sp_q, gp_q, cnt_q, gcnt_q;
  logic signed [VW-1:0] fsum_q, ssum_q, gsum_q, fav_q, sav_q, gav_q;
  logic [2:0] rdy_q;
  logic signed [PriceW-1:0] price_q, macd_q;
  logic signed [VW-1:0] macd_full_q;
  logic mv_q;
  logic ov_q;
  out_t res_q;

  logic dstart;
  logic signed [VW-1:0] dnum;
  logic [DW-1:0] dden;
  logic ddone;
  logic signed [VW-1:0] dquo;

  macd_div #(.NumW(VW), .DenW(DW)) u_div (
    .clk_i, .rst_ni, .start_i(dstart), .num_i(dnum), .den_i(dden),
    .done_o(ddone), .quo_o(dquo)
  );

  function automatic logic signed [PriceW-1:0] rnd_out(input logic signed [VW-1:0] x);
    logic signed [VW-1:0] y;
    y = (x + (GOne >>> 1)) >>> PRICE_FRAC_BITS;
    if (y > 64'sd2147483647) return 32'sh7fffffff;
    if (y < -64'sd2147483648) return 32'sh80000000;
    return y[PriceW-1:0];
  endfunction

  logic bad;
  assign bad = (fp_q == '0) || (sp_q == '0) || (gp_q == '0) || (fp_q >= sp_q);

  // seed mean: round(sum*G/p) = floor((2*sum*G + p) / 2p)
  // ema: floor((4*delta + d) / 2d), d = p+1
  logic signed [VW-1:0] pw_ext, fd, sd, gd;
  assign pw_ext = VW'(price_q) <<< PRICE_FRAC_BITS;
  assign fd = pw_ext - fav_q;
  assign sd = pw_ext - sav_q;
  assign gd = (VW'(macd_q) <<< PRICE_FRAC_BITS) - gav_q;

  logic accept, cfg_acc;
  assign cfg_ch.ready = (st_q == SIdle) && !ov_q;
  assign in_ch.ready  = (st_q == SIdle) && !ov_q && !cfg_ch.valid;
  assign accept  = in_ch.valid && in_ch.ready;
  assign cfg_acc = cfg_ch.valid && cfg_ch.ready;

  always_comb begin
    dstart = 1'b0; dnum = '0; dden = '0; st_d = st_q;
    unique case (st_q)
      SFast: begin
        dstart = 1'b1; st_d = SFastW;
        if (rdy_q[0]) begin
          dnum = (fd <<< 2) + VW'(fp_q) + 1; dden = DW'({fp_q, 1'b0}) + DW'(2);
        end else begin
          dnum = ((fsum_q + VW'(price_q)) <<< (PRICE_FRAC_BITS + 1)) + VW'(fp_q);
          dden = DW'({fp_q, 1'b0});
        end
      end
      SSlow: begin
        dstart = 1'b1; st_d = SSlowW;
        if (rdy_q[1]) begin
          dnum = (sd <<< 2) + VW'(sp_q) + 1; dden = DW'({sp_q, 1'b0}) + DW'(2);
        end else begin
          dnum = ((ssum_q + VW'(price_q)) <<< (PRICE_FRAC_BITS + 1)) + VW'(sp_q);
          dden = DW'({sp_q, 1'b0});
        end
      end
      SSig: begin
        dstart = 1'b1; st_d = SSigW;
        if (rdy_q[2]) begin
          dnum = (gd <<< 2) + VW'(gp_q) + 1; dden = DW'({gp_q, 1'b0}) + DW'(2);
        end else begin
          // gsum_q already holds this beat's macd (added in SGSeed)
          dnum = (gsum_q <<< (PRICE_FRAC_BITS + 1)) + VW'(gp_q);
          dden = DW'({gp_q, 1'b0});
        end
      end
      default: ;
    endcase
  end

  logic [PERIOD_BITS-1:0] cnt_n;
  assign cnt_n = (cnt_q < PMax) ? cnt_q + 1'b1 : cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= SIdle; fp_q <= PERIOD_BITS'(12); sp_q <= PERIOD_BITS'(26);
      gp_q <= PERIOD_BITS'(9); cnt_q <= '0; gcnt_q <= '0; rdy_q <= '0;
      fsum_q <= '0; ssum_q <= '0; gsum_q <= '0; fav_q <= '0; sav_q <= '0; gav_q <= '0;
      ov_q <= 1'b0; mv_q <= 1'b0;
      price_q <= '0; macd_q <= '0; macd_full_q <= '0; res_q <= '0;
    end else begin
      if (out_ch.valid && out_ch.ready) ov_q <= 1'b0;
      if (cfg_acc) begin
        unique case (cfg_ch.data.index)
          RegFast:   fp_q <= PERIOD_BITS'(cfg_ch.data.data);
          RegSlow:   sp_q <= PERIOD_BITS'(cfg_ch.data.data);
          RegSignal: gp_q <= PERIOD_BITS'(cfg_ch.data.data);
          default: ;
        endcase
        if (cfg_ch.data.index != RegSpare) begin
          cnt_q <= '0; gcnt_q <= '0; rdy_q <= '0;
          fsum_q <= '0; ssum_q <= '0; gsum_q <= '0;
          fav_q <= '0; sav_q <= '0; gav_q <= '0;
        end
      end else begin
        unique case (st_q)
          SIdle: if (accept) begin
            price_q <= in_ch.data.price;
            if (in_ch.data.restart || bad) begin
              cnt_q <= '0; gcnt_q <= '0; rdy_q <= '0;
              fsum_q <= '0; ssum_q <= '0; gsum_q <= '0;
              fav_q <= '0; sav_q <= '0; gav_q <= '0;
            end
            st_q <= bad ? SOut : SFast;
            mv_q <= 1'b0;
          end
          SFast: begin
            cnt_q <= cnt_n;
            if (!rdy_q[0]) fsum_q <= fsum_q + VW'(price_q);
            if (!rdy_q[0] && cnt_n != fp_q) st_q <= SSlow;
            else st_q <= st_d;
          end
          SFastW: if (ddone) begin
            if (rdy_q[0]) fav_q <= fav_q + dquo;
            else begin fav_q <= dquo; rdy_q[0] <= 1'b1; end
            st_q <= SSlow;
          end
          SSlow: begin
            if (!rdy_q[1]) ssum_q <= ssum_q + VW'(price_q);
            if (!rdy_q[1] && cnt_q != sp_q) st_q <= SMacd;
            else st_q <= st_d;
          end
          SSlowW: if (ddone) begin
            if (rdy_q[1]) sav_q <= sav_q + dquo;
            else begin sav_q <= dquo; rdy_q[1] <= 1'b1; end
            st_q <= SMacd;
          end
          SMacd: begin
            macd_full_q <= fav_q - sav_q;
            macd_q <= rnd_out(fav_q - sav_q);
            mv_q <= &rdy_q[1:0];
            st_q <= (&rdy_q[1:0]) ? SGSeed : SOut;
          end
          SGSeed: begin
            if (!rdy_q[2]) begin
              gsum_q <= gsum_q + VW'(macd_q);
              gcnt_q <= gcnt_q + 1'b1;
              st_q <= (gcnt_q + 1'b1 == gp_q) ? SSig : SOut;
            end else st_q <= SSig;
          end
          SSig: st_q <= st_d;
          SSigW: if (ddone) begin
            if (rdy_q[2]) gav_q <= gav_q + dquo;
            else begin gav_q <= dquo; rdy_q[2] <= 1'b1; end
            st_q <= SOut;
          end
          SOut: begin
            res_q.macd_valid <= mv_q;
            res_q.signal_valid <= mv_q && rdy_q[2];
            res_q.macd_value <= mv_q ? macd_q : '0;
            res_q.signal_value <= (mv_q && rdy_q[2]) ? rnd_out(gav_q) : '0;
            res_q.histogram_value <= (mv_q && rdy_q[2]) ? rnd_out(macd_full_q - gav_q) : '0;
            ov_q <= 1'b1;
            st_q <= SIdle;
          end
          default: st_q <= SIdle;
        endcase
      end
    end
  end

  assign out_ch.valid = ov_q;
  assign out_ch.data  = res_q;
endmodule

>>> rtl/macd_checker.sv
`timescale 1ns / 1ps
module macd_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic signed [31:0] macd_value_i,
  input logic macd_valid_i,
  input logic signal_valid_i
);
  a_no_in_while_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !in_ready_i) else $error("input taken while result pending");
  a_sig_needs_macd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && signal_valid_i |-> macd_valid_i) else $error("signal without macd");
  a_zero_invalid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !macd_valid_i |-> macd_value_i == 32'sd0) else $error("nonzero macd");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i) else $error("result dropped");
endmodule

bind macd_indicator macd_checker u_chk (
  .clk_i, .rst_ni,
  .in_valid_i(in_ch.valid), .in_ready_i(in_ch.ready),
  .out_valid_i(out_ch.valid), .out_ready_i(out_ch.ready),
  .macd_value_i(out_ch.data.macd_value),
  .macd_valid_i(out_ch.data.macd_valid),
  .signal_valid_i(out_ch.data.signal_valid)
);
